/* hw/rtl/clr_pkg.sv */
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants for the command line receiver
// Holds the character codes, the command name table, the queue entry type
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package clr_pkg;

  // Line buffer size and derived widths.
  localparam int LineMax  = 32;
  localparam int AddrW    = $clog2(LineMax);
  localparam int CntW     = $clog2(LineMax + 1);
  localparam int BytePosW = 6;
  localparam int IdxW     = 5;
  localparam int NameCount = 32;
  localparam int KeyLen   = 4;
  localparam int QDepth   = 2;

  // Character codes.
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLow  = 8'h20;
  localparam logic [7:0] ChHigh = 8'h7E;

  // Command names, first character in the most significant byte.
  localparam logic [31:0] NameTable [NameCount] = '{
    "REQ ", "BUZ ", "SPD ", "LEFT", "RIGT", "HIBM", "FFOG", "RFOG",
    "LOBM", "ALS ", "POS ", "ABAG", "DRL ", "ABS ", "DUBL", "RPM ",
    "EPD ", "CGS ", "SBLT", "IGON", "PARK", "MBLT", "BRAK", "VATS",
    "REVE", "NUTR", "FUEL", "RADR", "RDSW", "PIN ", "PINA", "IMMO"
  };

  // One classified item passed from the front end to the back end.
  typedef struct packed {
    logic       is_cr;
    logic [7:0] ch;
  } cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Result of a name lookup.
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
  } match_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkLoad
  } back_state_e;

  // Compares a key against every name; the names are distinct, so at most
  // one entry can hit and the index is the OR of the hitting indexes.
  function automatic match_t find_name(input logic [31:0] key);
    match_t m;
    m = '0;
    for (int i = 0; i < NameCount; i++) begin
      if (NameTable[i] == key) begin
        m.hit = 1'b1;
        m.idx = m.idx | IdxW'(i);
      end
    end
    return m;
  endfunction

endpackage

/* hw/rtl/clr_front.sv */
// ----------------------------------------------------------------------------
// clr_front: input classifier
// Accepts received characters and forwards carriage returns and printable
// bytes to the command queue; all other bytes are dropped here.
// ----------------------------------------------------------------------------
module clr_front import clr_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // rx_char[7:0]
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  logic is_cr;
  logic is_print;

  // Classify the incoming character.
  assign is_cr    = (s_axis_tdata == ChCr);
  assign is_print = (s_axis_tdata >= ChLow) && (s_axis_tdata <= ChHigh);

  // Take an item whenever the queue has room; only useful ones are queued.
  assign s_axis_tready    = !q_stat_i.full;
  assign push_o           = s_axis_tvalid && s_axis_tready && (is_cr || is_print);
  assign push_cmd_o.is_cr = is_cr;
  assign push_cmd_o.ch    = s_axis_tdata;

endmodule

/* hw/rtl/clr_queue.sv */
// ----------------------------------------------------------------------------
// clr_queue: command queue
// A two-entry FIFO that decouples the classifier from the line engine.
// ----------------------------------------------------------------------------
module clr_queue import clr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_cmd_i,
  input  logic    pop_i,
  output cmd_t    head_o,
  output q_stat_t stat_o
);

  localparam int PtrW = $clog2(QDepth);

  cmd_t                  mem_q [QDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [$clog2(QDepth+1)-1:0] cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign stat_o.full  = (cnt_q == ($clog2(QDepth+1))'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hw/rtl/clr_back.sv */
// ----------------------------------------------------------------------------
// clr_back: line engine
// Stores printable characters, looks up the command name on a carriage
// return and streams a matched line out of the line store byte by byte.
// ----------------------------------------------------------------------------
module clr_back import clr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                head_i,
  input  q_stat_t             q_stat_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // line_byte[7:0], byte_pos[13:8], zero[15:14]
  output logic [IdxW-1:0]     m_axis_tuser,  // cmd_index[4:0]
  output logic                m_axis_tlast   // last
);

  back_state_e           state_q, state_d;
  logic [7:0]            line_mem [LineMax];
  logic [7:0]            rd_data_q;
  logic [CntW-1:0]       count_q;
  logic [KeyLen-1:0][7:0] key_q;
  logic [IdxW-1:0]       idx_q;
  logic [CntW-1:0]       len_q;
  logic [CntW-1:0]       pos_q;
  logic                  out_valid_q;
  logic [7:0]            out_byte_q;
  logic [BytePosW-1:0]   out_pos_q;
  logic [IdxW-1:0]       out_idx_q;
  logic                  out_last_q;

  logic   out_free;
  logic   is_last;
  logic   take_char;
  logic   take_cr;
  logic   line_ok;
  logic   rd_en;
  logic   load;
  match_t match;

  // Name lookup on the first four stored characters.
  assign match     = find_name({key_q[0], key_q[1], key_q[2], key_q[3]});
  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_last   = (pos_q == len_q - 1'b1);
  assign take_char = pop_o && !head_i.is_cr;
  assign take_cr   = pop_o && head_i.is_cr;
  assign line_ok   = (count_q >= CntW'(KeyLen)) && match.hit;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (!q_stat_i.empty && head_i.is_cr && line_ok) begin
          state_d = BkRead;
        end
      end
      BkRead: begin
        state_d = BkLoad;
      end
      BkLoad: begin
        if (out_free) begin
          state_d = is_last ? BkIdle : BkRead;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o = 1'b0;
    rd_en = 1'b0;
    load  = 1'b0;
    case (state_q)
      BkIdle: begin
        pop_o = !q_stat_i.empty;
      end
      BkRead: begin
        rd_en = 1'b1;
      end
      BkLoad: begin
        load = out_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // Control registers: state, fill count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_cr) begin
        count_q <= '0;
      end else if (take_char && (count_q < CntW'(LineMax))) begin
        count_q <= count_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Line store: written as characters arrive, read one byte per emission.
  always_ff @(posedge clk_i) begin
    if (take_char && (count_q < CntW'(LineMax))) begin
      line_mem[count_q[AddrW-1:0]] <= head_i.ch;
    end
    if (rd_en) begin
      rd_data_q <= line_mem[pos_q[AddrW-1:0]];
    end
  end

  // Payload registers: name key, emission bookkeeping and output item.
  always_ff @(posedge clk_i) begin
    if (take_char && (count_q < CntW'(KeyLen))) begin
      key_q[count_q[$clog2(KeyLen)-1:0]] <= head_i.ch;
    end
    if (take_cr && line_ok) begin
      idx_q <= match.idx;
      len_q <= count_q;
      pos_q <= '0;
    end else if (load) begin
      pos_q <= pos_q + 1'b1;
    end
    if (load) begin
      out_byte_q <= rd_data_q;
      out_pos_q  <= BytePosW'(pos_q);
      out_idx_q  <= idx_q;
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_pos_q, out_byte_q};
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* hw/rtl/command_line_receiver.sv */
// ----------------------------------------------------------------------------
// command_line_receiver: serial command keyword recognizer
// Collects a text line and emits it, tagged with its command index, when its
// first four characters name a known command.
// ----------------------------------------------------------------------------
// A character is accepted whenever the two-entry command queue
// has room; printable characters (0x20..0x7E) are stored up to 32 per line,
// other bytes except carriage return are dropped. The line engine retires one
// stored character per cycle while it is not sending a line. On a carriage
// return the command name is checked combinationally; a matching line is then
// streamed out byte by byte, each byte read from the registered line store
// (BkRead) and then loaded into the output register (BkLoad), where the engine
// waits while the previous byte is held by a low tready. Meanwhile at most two
// more characters are taken into the queue; after that tready stays low until
// the line has been sent. Output bytes carry the command index on tuser, the
// byte and its position on tdata, and tlast on the final byte.
// ----------------------------------------------------------------------------
module command_line_receiver import clr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // rx_char[7:0]
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [15:0]     m_axis_tdata_o,   // line_byte[7:0], byte_pos[13:8], zero[15:14]
  output logic [IdxW-1:0] m_axis_tuser_o,   // cmd_index[4:0]
  output logic            m_axis_tlast_o    // last
);

  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;
  q_stat_t q_stat;

  // Classifier.
  clr_front u_front (
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  // Decoupling queue.
  clr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Line engine.
  clr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o),
    .m_axis_tuser  (m_axis_tuser_o),
    .m_axis_tlast  (m_axis_tlast_o)
  );

  // The queue can never report full and empty together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("command queue reports full and empty at once");

  // An emitted line always holds at least the four name characters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[13:8] >= 6'd3))
    else $error("line ended before the command name was complete");

  // A byte that is not the last one cannot sit at the final buffer position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[13:8] < 6'(LineMax - 1)))
    else $error("line continues past the end of the line store");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stream-level testbench for the command line receiver
// Sends characters through the input stream and checks every output item
// against a predictor of the line buffer and the name lookup or the directed
// table. A short table of directed characters comes first, then random lines,
// most led by a valid command name. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int IdxW       = clr_pkg::IdxW;
  localparam int LineLen    = clr_pkg::LineMax;
  localparam int NumNames   = 32;
  localparam int IdleLimit  = 2000;
  localparam int DrainCycles = 100;
  localparam int RandItems  = 405;
  localparam int NumRows    = 25;

  localparam logic [7:0] CharCr   = clr_pkg::ChCr;
  localparam logic [7:0] CharLow  = clr_pkg::ChLow;
  localparam logic [7:0] CharHigh = clr_pkg::ChHigh;

  // Command indexes that the directed table types in.
  localparam logic [IdxW-1:0] IdxReq  = IdxW'(0);
  localparam logic [IdxW-1:0] IdxImmo = IdxW'(31);

  // Known command names, first character in the top byte.
  localparam logic [31:0] CmdNames [NumNames] = '{
    "REQ ", "BUZ ", "SPD ", "LEFT", "RIGT", "HIBM", "FFOG", "RFOG",
    "LOBM", "ALS ", "POS ", "ABAG", "DRL ", "ABS ", "DUBL", "RPM ",
    "EPD ", "CGS ", "SBLT", "IGON", "PARK", "MBLT", "BRAK", "VATS",
    "REVE", "NUTR", "FUEL", "RADR", "RDSW", "PIN ", "PINA", "IMMO"
  };

  // How the expectation of a directed row is obtained.
  typedef enum logic [1:0] {
    RowPredicted,
    RowQuiet,
    RowEmits
  } row_kind_e;

  typedef struct packed {
    logic [7:0]      ch;
    row_kind_e       kind;
    logic [IdxW-1:0] idx;
    logic [5:0]      len;
  } stim_row_t;

  // One expected output item of an accepted line.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [7:0]      ch;
    logic [5:0]      pos;
    logic            last;
  } line_byte_t;

  // Directed characters: empty line, the lowest and highest printable bytes
  // inside matched lines, an unknown name and ignored bytes within a line.
  localparam stim_row_t DirRows [NumRows] = '{
    '{CharCr, RowQuiet,     '0,      6'd0},
    '{"R",    RowPredicted, '0,      6'd0},
    '{"E",    RowPredicted, '0,      6'd0},
    '{"Q",    RowPredicted, '0,      6'd0},
    '{" ",    RowPredicted, '0,      6'd0},
    '{CharCr, RowEmits,     IdxReq,  6'd4},
    '{"I",    RowPredicted, '0,      6'd0},
    '{"M",    RowPredicted, '0,      6'd0},
    '{"M",    RowPredicted, '0,      6'd0},
    '{"O",    RowPredicted, '0,      6'd0},
    '{"~",    RowPredicted, '0,      6'd0},
    '{CharCr, RowEmits,     IdxImmo, 6'd5},
    '{"X",    RowPredicted, '0,      6'd0},
    '{"Y",    RowPredicted, '0,      6'd0},
    '{"Z",    RowPredicted, '0,      6'd0},
    '{"W",    RowPredicted, '0,      6'd0},
    '{CharCr, RowQuiet,     '0,      6'd0},
    '{"P",    RowPredicted, '0,      6'd0},
    '{"I",    RowPredicted, '0,      6'd0},
    '{8'h00,  RowPredicted, '0,      6'd0},
    '{8'hFF,  RowPredicted, '0,      6'd0},
    '{"N",    RowPredicted, '0,      6'd0},
    '{8'h7F,  RowPredicted, '0,      6'd0},
    '{"A",    RowPredicted, '0,      6'd0},
    '{CharCr, RowPredicted, '0,      6'd0}
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            s_tvalid = 1'b0;
  logic [7:0]      s_tdata = 8'h00;
  logic            s_tready;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [15:0]     m_tdata;
  logic [IdxW-1:0] m_tuser;
  logic            m_tlast;

  // Predictor state: the line being collected.
  logic [7:0] line_buf [LineLen];
  int         line_len = 0;

  line_byte_t pending_bytes [$];

  int  mismatches = 0;
  int  chars_sent = 0;
  int  bytes_checked = 0;
  int  lines_matched = 0;
  int  full_drops = 0;
  int  idle_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  int  rx_hold = 0;
  int  rx_cycle = 0;

  command_line_receiver dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Updates the line buffer for one accepted character; on a carriage return
  // with a known name in front, queues the line's output items when asked to.
  task automatic predict_char(input logic [7:0] ch, input bit keep);
    logic [31:0] key;
    int          hit;
    if (ch == CharCr) begin
      if (line_len >= 4) begin
        key = {line_buf[0], line_buf[1], line_buf[2], line_buf[3]};
        hit = -1;
        for (int i = 0; i < NumNames; i++) begin
          if (CmdNames[i] == key) hit = i;
        end
        if (hit >= 0) begin
          lines_matched++;
          if (keep) begin
            for (int k = 0; k < line_len; k++) begin
              pending_bytes.push_back('{IdxW'(hit), line_buf[k], 6'(k), k == line_len - 1});
            end
          end
        end
      end
      line_len = 0;
    end else if (ch >= CharLow && ch <= CharHigh) begin
      if (line_len < LineLen) begin
        line_buf[line_len] = ch;
        line_len++;
      end else begin
        full_drops++;
      end
    end
  endtask

  // Offers one character, after a random gap unless in a burst, and waits until it is taken.
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  // Holds the input idle until every queued output item has come back.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() > 0) @(posedge clk);
  endtask

  // Output ready with random stalls and occasional stall-free stretches.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) begin
      rx_burst <= ($urandom_range(3) == 0);
    end
    if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!rx_burst && $urandom_range(2) == 0) rx_hold <= pick_gap();
    end
  end

  // Compares each accepted output item with the oldest expectation.
  always @(posedge clk) begin
    line_byte_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item idx=%0d byte=%02h pos=%0d",
                                  m_tuser, m_tdata[7:0], m_tdata[13:8]));
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (m_tuser !== want.idx)
          report_mismatch($sformatf("command index %0d, want %0d", m_tuser, want.idx));
        if (m_tdata[7:0] !== want.ch)
          report_mismatch($sformatf("line byte %02h, want %02h", m_tdata[7:0], want.ch));
        if (m_tdata[13:8] !== want.pos)
          report_mismatch($sformatf("byte position %0d, want %0d", m_tdata[13:8], want.pos));
        if (m_tdata[15:14] !== 2'b00)
          report_mismatch($sformatf("padding bits %b, want 00", m_tdata[15:14]));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b at position %0d",
                                    m_tlast, want.last, want.pos));
      end
    end
  end

  // Ends the run when neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without an accepted item", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] line_q [$];
    logic [7:0] b;
    int         r;
    int         pick;
    int         tail;
    int         rand_items;
    int         next_pause;

    rand_items = 0;
    next_pause = 150;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; typed rows take their line bytes from the rows above.
    for (int row = 0; row < NumRows; row++) begin
      send_char(DirRows[row].ch);
      predict_char(DirRows[row].ch, DirRows[row].kind == RowPredicted);
      if (DirRows[row].kind == RowEmits) begin
        for (int k = 0; k < DirRows[row].len; k++) begin
          pending_bytes.push_back('{DirRows[row].idx, DirRows[row - DirRows[row].len + k].ch,
                                    6'(k), k == DirRows[row].len - 1});
        end
      end
    end

    // Random lines: mostly a known name and a printable tail, the rest
    // near-miss names, short junk lines and raw bytes.
    while (rand_items < RandItems) begin
      tx_burst = ($urandom_range(4) == 0);
      line_q.delete();
      r = $urandom_range(99);
      if (r < 85) begin
        pick = $urandom_range(NumNames - 1);
        for (int i = 3; i >= 0; i--) line_q.push_back(CmdNames[pick][8*i +: 8]);
        // A near-miss name has one of its four characters replaced.
        if (r >= 72) line_q[$urandom_range(3)] = 8'($urandom_range(CharHigh, CharLow));
        tail = ($urandom_range(9) == 0) ? $urandom_range(40, 24) : $urandom_range(6);
        repeat (tail) line_q.push_back(8'($urandom_range(CharHigh, CharLow)));
        if ($urandom_range(3) == 0) begin
          b = $urandom_range(1) ? 8'($urandom_range(8'h1F, 8'h00))
                                : 8'($urandom_range(8'hFF, 8'h7F));
          if (b == CharCr) b = 8'h00;
          line_q.insert($urandom_range(line_q.size()), b);
        end
        // A few lines run on into the next one without a carriage return.
        if ($urandom_range(19) != 0) line_q.push_back(CharCr);
      end else if (r < 95) begin
        repeat ($urandom_range(5)) line_q.push_back(8'($urandom_range(CharHigh, CharLow)));
        line_q.push_back(CharCr);
      end else begin
        repeat ($urandom_range(6, 1)) line_q.push_back(8'($urandom_range(255)));
      end

      foreach (line_q[i]) begin
        send_char(line_q[i]);
        predict_char(line_q[i], 1'b1);
        if (line_q[i] == CharCr || (line_q[i] >= CharLow && line_q[i] <= CharHigh))
          rand_items++;
      end

      if (rand_items >= next_pause) begin
        hold_until_drained();
        next_pause += 150;
      end
    end

    // Let the last lines come out, then allow for stray extra items.
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d characters; %0d lines matched a command name.",
             chars_sent, lines_matched);
    $display("Checked %0d output items; %0d characters dropped on a full line.",
             bytes_checked, full_drops);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/clr_pkg.sv
hw/rtl/clr_front.sv
hw/rtl/clr_queue.sv
hw/rtl/clr_back.sv
hw/rtl/command_line_receiver.sv
dv/tb.sv
